### src/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared types and constants for the stick gesture selector.
// ----------------------------------------------------------------------------
`default_nettype none

package sgs_pkg;

	// hold counter width (8..32) and flick count limit (1..63)
	localparam int COUNTER_WIDTH = 16;
	localparam int MAX_SELECTION = 15;

	localparam int FLICK_W = $clog2(MAX_SELECTION + 1);
	// wide enough for the counter and every 15 bit tick register, plus sign
	localparam int CMP_W   = ((COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16) + 1;

	localparam logic signed [COUNTER_WIDTH-1:0] CNT_MAX =
		{1'b0, {(COUNTER_WIDTH-1){1'b1}}};
	localparam logic signed [COUNTER_WIDTH-1:0] CNT_MIN =
		{1'b1, {(COUNTER_WIDTH-1){1'b0}}};

	// config port
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_STICK_THRESHOLD = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_START_TICKS     = 8'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_VERIFY_TICKS    = 8'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_STOP_TICKS      = 8'd3;

	localparam logic [9:0]  RST_STICK_THRESHOLD = 10'd600;
	localparam logic [14:0] RST_START_TICKS     = 15'd2000;
	localparam logic [14:0] RST_VERIFY_TICKS    = 15'd40;
	localparam logic [14:0] RST_STOP_TICKS      = 15'd1000;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 16;

	typedef logic signed [COUNTER_WIDTH-1:0] cnt_t;
	typedef logic [FLICK_W-1:0] flick_t;

	typedef struct packed {
		logic [9:0]  stick_threshold;
		logic [14:0] start_ticks;
		logic [14:0] verify_ticks;
		logic [14:0] stop_ticks;
	} sgs_cfg_t;

	typedef struct packed {
		logic              left_switch_down;
		logic              right_switch_down;
		logic signed [10:0] stick_x_right;
		logic signed [10:0] stick_x_left;
		logic              busy_req;
	} sgs_item_t;

	typedef struct packed {
		logic   mode_selecting;
		flick_t flick_count;
		cnt_t   hold_counter;
	} sgs_state_t;

	typedef struct packed {
		logic       selecting;
		logic       hold_verified;
		logic       begin_event;
		logic       select_done;
		logic [3:0] selection;
		logic       gyro_request;
	} sgs_result_t;

endpackage

`default_nettype wire

### src/sgs_update.sv
// ----------------------------------------------------------------------------
// sgs_update
// Next-state and result logic for one tick of the gesture selector.
// ----------------------------------------------------------------------------
`default_nettype none

module sgs_update (
	input  sgs_pkg::sgs_cfg_t    cfg,
	input  sgs_pkg::sgs_item_t   item,
	input  sgs_pkg::sgs_state_t  cur,
	output sgs_pkg::sgs_state_t  nxt,
	output sgs_pkg::sgs_result_t res
);

	logic signed [11:0] thr;
	logic signed [11:0] xr;
	logic signed [11:0] xl;
	logic               inward;
	logic               outward;

	sgs_pkg::cnt_t cnt0;
	sgs_pkg::cnt_t cnt_up;
	sgs_pkg::cnt_t cnt1;

	logic signed [sgs_pkg::CMP_W-1:0] cnt0_x;
	logic signed [sgs_pkg::CMP_W-1:0] cnt1_x;
	logic signed [sgs_pkg::CMP_W-1:0] verify_x;
	logic signed [sgs_pkg::CMP_W-1:0] start_x;
	logic signed [sgs_pkg::CMP_W-1:0] stop_x;

	sgs_pkg::flick_t flick1;
	logic [7:0]      flick_w;

	assign thr = signed'({2'b00, cfg.stick_threshold});
	assign xr  = 12'(item.stick_x_right);
	assign xl  = 12'(item.stick_x_left);

	assign inward  = (xr < -thr) && (xl > thr);
	assign outward = (xr > thr) && (xl < -thr);

	assign cnt0     = cur.hold_counter;
	assign cnt0_x   = sgs_pkg::CMP_W'(cnt0);
	assign verify_x = signed'({{(sgs_pkg::CMP_W-15){1'b0}}, cfg.verify_ticks});
	assign start_x  = signed'({{(sgs_pkg::CMP_W-15){1'b0}}, cfg.start_ticks});
	assign stop_x   = signed'({{(sgs_pkg::CMP_W-15){1'b0}}, cfg.stop_ticks});

	// saturating count toward the top; negative values snap to zero
	always_comb begin
		if (cnt0 < 0) begin
			cnt_up = '0;
		end else if (cnt0 < sgs_pkg::CNT_MAX) begin
			cnt_up = cnt0 + sgs_pkg::cnt_t'(1);
		end else begin
			cnt_up = cnt0;
		end
	end

	always_comb begin
		cnt1   = cnt0;
		flick1 = cur.flick_count;
		if (!cur.mode_selecting && inward) begin
			cnt1 = cnt_up;
		end else if (cur.mode_selecting && outward) begin
			cnt1 = cnt_up;
		end else if (cur.mode_selecting && (cnt0_x >= verify_x) && !inward) begin
			// flick released after a verified hold
			cnt1 = '0;
			if (cur.flick_count < sgs_pkg::FLICK_W'(sgs_pkg::MAX_SELECTION)) begin
				flick1 = cur.flick_count + sgs_pkg::flick_t'(1);
			end
		end else if (cnt0 > sgs_pkg::CNT_MIN) begin
			cnt1 = cnt0 - sgs_pkg::cnt_t'(1);
		end
	end

	assign cnt1_x  = sgs_pkg::CMP_W'(cnt1);
	assign flick_w = 8'(flick1);

	always_comb begin
		nxt = cur;
		res = '0;
		if (item.busy_req) begin
			nxt.mode_selecting = 1'b0;
			nxt.flick_count    = '0;
		end else if (!(item.left_switch_down && item.right_switch_down)) begin
			nxt.mode_selecting = 1'b0;
			nxt.flick_count    = '0;
			nxt.hold_counter   = '0;
		end else begin
			nxt.mode_selecting = cur.mode_selecting;
			nxt.flick_count    = flick1;
			nxt.hold_counter   = cnt1;
			res.hold_verified  = cur.mode_selecting && (cnt1_x >= verify_x);
			if (!cur.mode_selecting && (cnt1_x >= start_x)) begin
				nxt.mode_selecting = 1'b1;
				nxt.flick_count    = '0;
				nxt.hold_counter   = '0;
				res.begin_event    = 1'b1;
			end else if (cur.mode_selecting && (cnt1_x <= -stop_x)) begin
				res.select_done    = 1'b1;
				res.selection      = (flick_w > 8'd15) ? 4'd15 : flick_w[3:0];
				res.gyro_request   = (flick_w == 8'd1);
				nxt.mode_selecting = 1'b0;
				nxt.flick_count    = '0;
				nxt.hold_counter   = '0;
			end
		end
		res.selecting = nxt.mode_selecting;
	end

endmodule

`default_nettype wire

### src/stick_gesture_selector_core.sv
// ----------------------------------------------------------------------------
// stick_gesture_selector_core
// Remote-control stick gesture recognizer with streaming in/out and a
// register write port.
// ----------------------------------------------------------------------------
// One input word per control tick, one result word per input word. A word is
// taken into an input register, then the gesture state and the result register
// are updated together when the word advances, and a new word is taken every
// cycle while the result side keeps up; a stalled result holds the input
// register, and s_tready drops only when both are full.
// Register writes are always accepted and should be made while no word is
// in flight.
`default_nettype none

module stick_gesture_selector_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [0] left_switch_down, [1] right_switch_down, [12:2] stick_x_right,
	// [23:13] stick_x_left, [24] busy_req, [31:25] zero
	input  wire logic [sgs_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [0] selecting, [1] hold_verified, [2] begin_event, [3] select_done,
	// [7:4] selection, [8] gyro_request, [15:9] zero
	output logic [sgs_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sgs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [sgs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	sgs_pkg::sgs_cfg_t    cfg_q;
	sgs_pkg::sgs_state_t  state_q;
	sgs_pkg::sgs_state_t  state_nxt;
	sgs_pkg::sgs_item_t   item_s1;
	sgs_pkg::sgs_result_t res;
	logic                 valid_s1;
	logic                 advance;
	logic [sgs_pkg::OUT_DATA_W-1:0] out_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tdata   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_threshold <= sgs_pkg::RST_STICK_THRESHOLD;
			cfg_q.start_ticks     <= sgs_pkg::RST_START_TICKS;
			cfg_q.verify_ticks    <= sgs_pkg::RST_VERIFY_TICKS;
			cfg_q.stop_ticks      <= sgs_pkg::RST_STOP_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				sgs_pkg::REG_STICK_THRESHOLD: cfg_q.stick_threshold <= cfg_data[9:0];
				sgs_pkg::REG_START_TICKS:     cfg_q.start_ticks     <= cfg_data[14:0];
				sgs_pkg::REG_VERIFY_TICKS:    cfg_q.verify_ticks    <= cfg_data[14:0];
				sgs_pkg::REG_STOP_TICKS:      cfg_q.stop_ticks      <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.left_switch_down  <= s_tdata[0];
			item_s1.right_switch_down <= s_tdata[1];
			item_s1.stick_x_right     <= signed'(s_tdata[12:2]);
			item_s1.stick_x_left      <= signed'(s_tdata[23:13]);
			item_s1.busy_req          <= s_tdata[24];
		end
	end

	sgs_update u_update (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= {7'd0, res.gyro_request, res.selection, res.select_done,
				res.begin_event, res.hold_verified, res.selecting};
		end
	end

endmodule

`default_nettype wire

### sim/tb_stick_gesture_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stick_gesture_selector_core
// Self-checking bench for the stick gesture selector. Ticks are fed on the
// input stream and every result word is compared field by field against a
// local model of the gesture logic. Runs directed gestures, extreme settings,
// output back-pressure, long holds and random gesture traffic.
// ----------------------------------------------------------------------------

module tb_stick_gesture_selector_core;

	localparam int RANDOM_TICKS    = 1100;
	localparam int LONG_RUN        = 60;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int MAX_REPORTS     = 20;
	// an index outside the register map; writes to it must change nothing
	localparam logic [sgs_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 8'hA5;

	typedef enum {G_INWARD, G_OUTWARD, G_QUIET} gesture_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [sgs_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [sgs_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [sgs_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [sgs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	stick_gesture_selector_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	// gesture model state and its copy of the registers
	bit            sel_mode;
	int            flicks;
	sgs_pkg::cnt_t hold_cnt;
	int            cfg_thr;
	int            cfg_start;
	int            cfg_verify;
	int            cfg_stop;

	sgs_pkg::sgs_item_t   feed_q[$];
	sgs_pkg::sgs_result_t results_q[$];

	bit fast_feed;
	bit hold_off_req;
	int ticks_sent;
	int results_checked;
	int reg_writes;
	int mismatches;
	int n_begin;
	int n_done;
	int n_gyro;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic sgs_pkg::sgs_result_t gesture_step(input sgs_pkg::sgs_item_t it);
		sgs_pkg::sgs_result_t r;
		int hc, xr, xl, cmax, cmin;
		bit inward, outward;
		r = '0;
		cmax = sgs_pkg::CNT_MAX;
		cmin = sgs_pkg::CNT_MIN;
		hc = hold_cnt;
		xr = it.stick_x_right;
		xl = it.stick_x_left;
		if (it.busy_req) begin
			// abort keeps the hold counter
			sel_mode = 1'b0;
			flicks = 0;
		end else if (!(it.left_switch_down && it.right_switch_down)) begin
			hc = 0;
			sel_mode = 1'b0;
			flicks = 0;
		end else begin
			inward = (xr < -cfg_thr) && (xl > cfg_thr);
			outward = (xr > cfg_thr) && (xl < -cfg_thr);
			if ((!sel_mode && inward) || (sel_mode && outward)) begin
				if (hc < 0)
					hc = 0;
				else if (hc < cmax)
					hc++;
			end else if (sel_mode && hc >= cfg_verify && !inward) begin
				hc = 0;
				if (flicks < sgs_pkg::MAX_SELECTION)
					flicks++;
			end else if (hc > cmin) begin
				hc--;
			end
			r.hold_verified = sel_mode && (hc >= cfg_verify);
			if (!sel_mode && hc >= cfg_start) begin
				sel_mode = 1'b1;
				flicks = 0;
				hc = 0;
				r.begin_event = 1'b1;
			end else if (sel_mode && hc <= -cfg_stop) begin
				r.select_done = 1'b1;
				r.selection = (flicks > 15) ? 4'd15 : 4'(flicks);
				r.gyro_request = (flicks == 1);
				sel_mode = 1'b0;
				flicks = 0;
				hc = 0;
			end
		end
		hold_cnt = sgs_pkg::cnt_t'(hc);
		r.selecting = sel_mode;
		return r;
	endfunction

	function automatic sgs_pkg::sgs_item_t mk_item(bit lsd, bit rsd, int xr, int xl, bit busy);
		sgs_pkg::sgs_item_t it;
		it.left_switch_down = lsd;
		it.right_switch_down = rsd;
		it.stick_x_right = 11'(xr);
		it.stick_x_left = 11'(xl);
		it.busy_req = busy;
		return it;
	endfunction

	// strictly above +thr (pinned at full scale when nothing is above)
	function automatic int past_pos(int thr);
		return (thr >= 1023) ? 1023 : int'($urandom_range(1023, thr + 1));
	endfunction

	// strictly below -thr
	function automatic int past_neg(int thr);
		return -int'($urandom_range(1024, thr + 1));
	endfunction

	function automatic int near_zero(int thr);
		return int'($urandom_range(0, 2 * thr)) - thr;
	endfunction

	function automatic sgs_pkg::sgs_item_t gesture_item(gesture_t kind);
		case (kind)
			G_INWARD:  return mk_item(1, 1, past_neg(cfg_thr), past_pos(cfg_thr), 0);
			G_OUTWARD: return mk_item(1, 1, past_pos(cfg_thr), past_neg(cfg_thr), 0);
			default:   return mk_item(1, 1, near_zero(cfg_thr), near_zero(cfg_thr), 0);
		endcase
	endfunction

	function automatic sgs_pkg::sgs_item_t noise_item();
		sgs_pkg::sgs_item_t it;
		it.left_switch_down = ($urandom_range(0, 3) != 0);
		it.right_switch_down = ($urandom_range(0, 3) != 0);
		it.stick_x_right = 11'($urandom());
		it.stick_x_left = 11'($urandom());
		it.busy_req = ($urandom_range(0, 7) == 0);
		return it;
	endfunction

	task automatic send_tick(input sgs_pkg::sgs_item_t it);
		while (feed_q.size() >= 2)
			@(posedge clk);
		feed_q.push_back(it);
		ticks_sent++;
	endtask

	task automatic send_run(gesture_t kind, int n);
		repeat (n) send_tick(gesture_item(kind));
	endtask

	task automatic wait_idle();
		while (feed_q.size() != 0 || results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [sgs_pkg::CFG_ADDR_W-1:0] addr, int value);
		logic [sgs_pkg::CFG_DATA_W-1:0] data;
		// junk above the register width must be dropped
		data = sgs_pkg::CFG_DATA_W'($urandom());
		case (addr)
			sgs_pkg::REG_STICK_THRESHOLD: data[9:0] = value[9:0];
			sgs_pkg::REG_START_TICKS, sgs_pkg::REG_VERIFY_TICKS,
			sgs_pkg::REG_STOP_TICKS: data[14:0] = value[14:0];
			default: ;
		endcase
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (addr)
			sgs_pkg::REG_STICK_THRESHOLD: cfg_thr = data[9:0];
			sgs_pkg::REG_START_TICKS:     cfg_start = data[14:0];
			sgs_pkg::REG_VERIFY_TICKS:    cfg_verify = data[14:0];
			sgs_pkg::REG_STOP_TICKS:      cfg_stop = data[14:0];
			default: ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(int thr, int start, int verify, int stop);
		wait_idle();
		write_reg(sgs_pkg::REG_STICK_THRESHOLD, thr);
		write_reg(sgs_pkg::REG_START_TICKS, start);
		write_reg(sgs_pkg::REG_VERIFY_TICKS, verify);
		write_reg(sgs_pkg::REG_STOP_TICKS, stop);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNMAPPED, $urandom());
	endtask

	// enter, a random number of flicks, then a quiet stretch to finish
	task automatic gesture_round();
		int n_flicks, hold;
		send_run(G_INWARD, cfg_start + 1 + $urandom_range(0, 2));
		n_flicks = $urandom_range(0, 18);
		repeat (n_flicks) begin
			if ($urandom_range(0, 6) == 0)
				hold = $urandom_range(0, cfg_verify);
			else
				hold = cfg_verify + $urandom_range(1, 3);
			send_run(G_OUTWARD, hold);
			send_run(G_QUIET, $urandom_range(1, 2));
			if ($urandom_range(0, 19) == 0)
				send_tick(noise_item());
		end
		send_run(G_QUIET, cfg_stop + $urandom_range(1, 3));
	endtask

	task automatic noise_round();
		repeat ($urandom_range(1, 12)) send_tick(noise_item());
	endtask

	task automatic test_directed();
		// reset settings: one switch up, then the other
		send_tick(mk_item(1, 0, 0, 0, 0));
		send_tick(mk_item(0, 1, -1024, 1023, 0));
		configure(100, 3, 2, 3);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		send_tick(mk_item(1, 1, -1024, 1023, 1));
		repeat (4) send_tick(mk_item(1, 1, -1024, 1023, 0));
		repeat (3) send_tick(mk_item(1, 1, 1023, -1024, 0));
		// release counts the flick, quiet ends with a count of one
		repeat (5) send_tick(mk_item(1, 1, 0, 0, 0));
		repeat (4) send_tick(mk_item(1, 1, -101, 101, 0));
		repeat (2) send_tick(mk_item(1, 1, 101, -101, 0));
		// exactly at threshold is not deflected
		send_tick(mk_item(1, 1, 100, -100, 0));
		send_tick(mk_item(1, 1, 0, 0, 1));
	endtask

	task automatic test_config_extremes();
		configure(0, 0, 0, 0);
		gesture_round();
		noise_round();
		send_run(G_QUIET, 3);
		configure(1023, 32767, 32767, 32767);
		noise_round();
		send_run(G_INWARD, 4);
		send_run(G_QUIET, 4);
		configure(1023, 0, 0, 0);
		noise_round();
		send_run(G_QUIET, 3);
	endtask

	task automatic test_backpressure();
		wait_idle();
		hold_off_req = 1'b1;
		repeat (40) send_tick(noise_item());
		wait_idle();
	endtask

	task automatic test_long_holds();
		fast_feed = 1'b1;
		configure(300, 1, 32767, 32767);
		send_tick(mk_item(0, 0, 0, 0, 0));
		// idle count-down goes negative, inward snaps it back to zero
		send_run(G_QUIET, LONG_RUN);
		send_run(G_INWARD, 3);
		// outward and quiet holds far short of the verify and stop times
		send_run(G_OUTWARD, LONG_RUN);
		send_run(G_QUIET, LONG_RUN);
		wait_idle();
		fast_feed = 1'b0;
	endtask

	task automatic test_random_gestures();
		int base, thr, roll;
		configure(100, 4, 3, 6);
		base = ticks_sent;
		while (ticks_sent - base < RANDOM_TICKS) begin
			if ($urandom_range(0, 5) == 0) begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					thr = 0;
				else if (roll == 1)
					thr = 1023;
				else if (roll < 4)
					thr = $urandom_range(1, 20);
				else
					thr = $urandom_range(0, 1022);
				configure(thr, $urandom_range(0, 10), $urandom_range(0, 6),
					$urandom_range(0, 15));
			end
			if ($urandom_range(0, 4) == 0)
				noise_round();
			else
				gesture_round();
		end
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, name, want, got);
		end
	endtask

	// input side: takes ticks from the queue, adds gaps, predicts on accept
	initial begin : feeder
		int gap_left, roll;
		sgs_pkg::sgs_result_t want;
		gap_left = 0;
		forever begin
			@(posedge clk);
			if (s_tvalid && s_tready) begin
				want = gesture_step(feed_q.pop_front());
				results_q.push_back(want);
				n_begin += want.begin_event;
				n_done += want.select_done;
				n_gyro += want.gyro_request;
				roll = $urandom_range(0, 99);
				if (fast_feed)
					gap_left = (roll < 2) ? 1 : 0;
				else if (roll < 60)
					gap_left = 0;
				else if (roll < 92)
					gap_left = $urandom_range(1, 3);
				else
					gap_left = $urandom_range(4, 20);
			end
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (feed_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, feed_q[0].busy_req, feed_q[0].stick_x_left,
					feed_q[0].stick_x_right, feed_q[0].right_switch_down,
					feed_q[0].left_switch_down};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side: checks each word and stalls at random
	initial begin : drain
		int stall_left, run_left, roll;
		sgs_pkg::sgs_result_t want;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (results_q.size() == 0) begin
					mismatches++;
					$display("%0t ns: result word %h with nothing expected", $time, m_tdata);
				end else begin
					want = results_q.pop_front();
					results_checked++;
					check_field("selecting", want.selecting, m_tdata[0]);
					check_field("hold_verified", want.hold_verified, m_tdata[1]);
					check_field("begin_event", want.begin_event, m_tdata[2]);
					check_field("select_done", want.select_done, m_tdata[3]);
					check_field("selection", want.selection, m_tdata[7:4]);
					check_field("gyro_request", want.gyro_request, m_tdata[8]);
				end
			end
			if (hold_off_req) begin
				stall_left = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end else if (stall_left == 0 && run_left == 0) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)
					stall_left = $urandom_range(1, 3);
				else if (roll < 11)
					stall_left = $urandom_range(10, 40);
				else if (roll < 19)
					run_left = $urandom_range(10, 60);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (run_left > 0)
					run_left--;
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
			$time, WATCHDOG_LIMIT, results_q.size());
		$display("FAIL stick_gesture_selector_core");
		$finish;
	end

	initial begin
		sel_mode = 1'b0;
		flicks = 0;
		hold_cnt = '0;
		cfg_thr = sgs_pkg::RST_STICK_THRESHOLD;
		cfg_start = sgs_pkg::RST_START_TICKS;
		cfg_verify = sgs_pkg::RST_VERIFY_TICKS;
		cfg_stop = sgs_pkg::RST_STOP_TICKS;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_backpressure();
		test_long_holds();
		test_random_gestures();
		wait_idle();
		$display("Ran %0d ticks over directed, extreme-setting, hold-off, long-hold and random",
			ticks_sent);
		$display("gesture tests: %0d results checked, %0d writes, %0d entries, %0d done, %0d gyro",
			results_checked, reg_writes, n_begin, n_done, n_gyro);
		if (mismatches == 0)
			$display("PASS stick_gesture_selector_core");
		else
			$display("FAIL stick_gesture_selector_core");
		$finish;
	end

endmodule
